@@ hdl/bafc_pkg.sv @@
// Shared constants, register indexes, event codes and control types of the autofire controller.
package bafc_pkg;

	localparam int TIME_BITS_DEF  = 48;
	localparam int BTN_BITS       = 64;
	localparam int MS_BITS        = 16;
	localparam int PERIOD_BITS    = 27;
	localparam int PRESS_US_BITS  = 26;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 64;

	localparam int HOLD_DELAY_US    = 200000;
	localparam int RELEASE_GUARD_US = 30000;
	localparam int US_PER_MS        = 1000;

	localparam logic [MS_BITS-1:0] PRESS_MS_RST   = 16'd100;
	localparam logic [MS_BITS-1:0] RELEASE_MS_RST = 16'd100;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_AUTOFIRE_MASK   = 3'd0;
	localparam cfg_idx_t REG_PRESS_MS        = 3'd1;
	localparam cfg_idx_t REG_RELEASE_MS      = 3'd2;
	localparam cfg_idx_t REG_DELAY_START     = 3'd3;
	localparam cfg_idx_t REG_RIGHT_HAND      = 3'd4;
	localparam cfg_idx_t REG_LEFT_SIDE_MASK  = 3'd5;
	localparam cfg_idx_t REG_RIGHT_SIDE_MASK = 3'd6;

	typedef logic [1:0] event_t;
	localparam event_t EV_IDLE      = 2'd0;
	localparam event_t EV_STARTING  = 2'd1;
	localparam event_t EV_EXECUTING = 2'd2;
	localparam event_t EV_FINISHING = 2'd3;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic commit;
	} bafc_cmd_t;

	typedef struct packed {
		logic active;
		logic div_done;
	} bafc_status_t;

endpackage

@@ hdl/bafc_poll_if.sv @@
// Poll channel: valid/ready handshake with the button set, half-controller flag and timestamp.
interface bafc_poll_if
	import bafc_pkg::*;
	#(parameter int TIME_BITS = TIME_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic [BTN_BITS-1:0]  pad_buttons;
	logic                 half_controller;
	logic [TIME_BITS-1:0] now_us;

	modport source (output valid, pad_buttons, half_controller, now_us, input ready);
	modport sink   (input valid, pad_buttons, half_controller, now_us, output ready);
endinterface

@@ hdl/bafc_result_if.sv @@
// Result channel: valid/ready handshake with the event code and the driven buttons.
interface bafc_result_if
	import bafc_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [1:0]          event_code;
	logic [BTN_BITS-1:0] drive_buttons;
	logic                drive_written;

	modport source (output valid, event_code, drive_buttons, drive_written, input ready);
	modport sink   (input valid, event_code, drive_buttons, drive_written, output ready);
endinterface

@@ hdl/bafc_div.sv @@
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module bafc_div
	import bafc_pkg::*;
	#(
		parameter int DVD_BITS = TIME_BITS_DEF,
		parameter int DVS_BITS = PERIOD_BITS
	) (
		input  logic                clk,
		input  logic                arst_n,
		input  logic                start,
		input  logic [DVD_BITS-1:0] dividend,
		input  logic [DVS_BITS-1:0] divisor,
		output logic                done,
		output logic [DVS_BITS-1:0] remainder
	);

	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DVD_BITS-1:0] dvd_q;
	logic [DVS_BITS-1:0] dvs_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DVS_BITS:0]   trial;
	logic [DVS_BITS-1:0] rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_BITS-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = DVS_BITS'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = trial[DVS_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ hdl/bafc_dp.sv @@
// Datapath: configuration registers, autofire state, period divider and result register.
module bafc_dp
	import bafc_pkg::*;
	#(parameter int TIME_BITS = TIME_BITS_DEF) (
		input  logic                     clk,
		input  logic                     arst_n,
		input  logic                     cfg_we,
		input  cfg_idx_t                 cfg_idx,
		input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
		input  logic [BTN_BITS-1:0]      pad_buttons,
		input  logic                     half_controller,
		input  logic [TIME_BITS-1:0]     now_us,
		input  bafc_cmd_t                cmd,
		output bafc_status_t             status,
		output event_t                   event_code,
		output logic [BTN_BITS-1:0]      drive_buttons,
		output logic                     drive_written
	);

	// configuration
	logic [BTN_BITS-1:0] autofire_mask_q;
	logic [MS_BITS-1:0]  press_ms_q;
	logic [MS_BITS-1:0]  release_ms_q;
	logic                delay_start_q;
	logic                right_hand_q;
	logic [BTN_BITS-1:0] left_mask_q;
	logic [BTN_BITS-1:0] right_mask_q;

	// autofire state
	logic                 active_q;
	logic                 press_phase_q;
	logic [TIME_BITS-1:0] start_us_q;
	logic [TIME_BITS-1:0] hold_start_q;
	logic                 hold_timing_q;

	// latched poll and per-poll values
	logic [BTN_BITS-1:0]      pad_q;
	logic                     half_q;
	logic [TIME_BITS-1:0]     now_q;
	logic [PRESS_US_BITS-1:0] press_us_q;
	logic                     zero_period_q;

	// result register
	event_t              code_q;
	logic [BTN_BITS-1:0] drive_q;
	logic                written_q;

	logic [MS_BITS:0]         period_ms;
	logic [PERIOD_BITS-1:0]   period_us;
	logic [TIME_BITS-1:0]     elapsed;
	logic                     div_done;
	logic [PERIOD_BITS-1:0]   div_rem;
	logic [PERIOD_BITS-1:0]   pos;
	logic [BTN_BITS-1:0]      wl;
	logic [BTN_BITS-1:0]      auto_set;
	logic [BTN_BITS-1:0]      normal_set;
	logic [TIME_BITS-1:0]     hold_base;
	logic [TIME_BITS-1:0]     held;
	logic                     finish;
	logic                     phase_now;

	logic                 active_d;
	logic                 press_phase_d;
	logic [TIME_BITS-1:0] start_us_d;
	logic [TIME_BITS-1:0] hold_start_d;
	logic                 hold_timing_d;
	event_t               code_d;
	logic [BTN_BITS-1:0]  drive_d;
	logic                 written_d;

	assign period_ms = {1'b0, press_ms_q} + {1'b0, release_ms_q};
	assign period_us = PERIOD_BITS'(period_ms) * PERIOD_BITS'(US_PER_MS);
	assign elapsed   = now_us - start_us_q;

	bafc_div #(
		.DVD_BITS (TIME_BITS),
		.DVS_BITS (PERIOD_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (elapsed),
		.divisor   (period_us),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			autofire_mask_q <= '0;
			press_ms_q      <= PRESS_MS_RST;
			release_ms_q    <= RELEASE_MS_RST;
			delay_start_q   <= 1'b1;
			right_hand_q    <= 1'b1;
			left_mask_q     <= '0;
			right_mask_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_AUTOFIRE_MASK:   autofire_mask_q <= cfg_wdata[BTN_BITS-1:0];
				REG_PRESS_MS:        press_ms_q      <= cfg_wdata[MS_BITS-1:0];
				REG_RELEASE_MS:      release_ms_q    <= cfg_wdata[MS_BITS-1:0];
				REG_DELAY_START:     delay_start_q   <= cfg_wdata[0];
				REG_RIGHT_HAND:      right_hand_q    <= cfg_wdata[0];
				REG_LEFT_SIDE_MASK:  left_mask_q     <= cfg_wdata[BTN_BITS-1:0];
				REG_RIGHT_SIDE_MASK: right_mask_q    <= cfg_wdata[BTN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pad_q         <= pad_buttons;
			half_q        <= half_controller;
			now_q         <= now_us;
			press_us_q    <= PRESS_US_BITS'(press_ms_q) * PRESS_US_BITS'(US_PER_MS);
			zero_period_q <= (period_ms == '0);
		end
	end

	// evaluate one poll from the latched fields and the period position
	always_comb begin
		wl         = autofire_mask_q;
		if (half_q) begin
			wl = wl & (right_hand_q ? right_mask_q : left_mask_q);
		end
		auto_set   = pad_q & wl;
		normal_set = pad_q & ~wl;
		pos        = zero_period_q ? '0 : div_rem;
		phase_now  = {1'b0, pos} < {1'b0, PERIOD_BITS'(press_us_q)};
		finish     = press_phase_q && (pos >= PERIOD_BITS'(RELEASE_GUARD_US))
			&& (auto_set == '0);
		hold_base  = hold_timing_q ? hold_start_q : now_q;
		held       = now_q - hold_base;

		active_d      = active_q;
		press_phase_d = press_phase_q;
		start_us_d    = start_us_q;
		hold_start_d  = hold_start_q;
		hold_timing_d = hold_timing_q;
		code_d        = EV_IDLE;
		drive_d       = pad_q;
		written_d     = 1'b0;

		if (active_q) begin
			written_d = 1'b1;
			if (finish) begin
				code_d        = EV_FINISHING;
				active_d      = 1'b0;
				press_phase_d = 1'b0;
				start_us_d    = '0;
				hold_start_d  = '0;
				hold_timing_d = 1'b0;
			end else begin
				code_d        = EV_EXECUTING;
				press_phase_d = phase_now;
				drive_d       = phase_now ? (normal_set | auto_set) : normal_set;
			end
		end else if (auto_set != '0) begin
			if (delay_start_q && (held < TIME_BITS'(HOLD_DELAY_US))) begin
				hold_start_d  = hold_base;
				hold_timing_d = 1'b1;
			end else begin
				code_d        = EV_STARTING;
				hold_timing_d = 1'b0;
				hold_start_d  = '0;
				active_d      = 1'b1;
				press_phase_d = 1'b1;
				start_us_d    = now_q;
			end
		end else begin
			hold_timing_d = 1'b0;
			hold_start_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			press_phase_q <= 1'b0;
			start_us_q    <= '0;
			hold_start_q  <= '0;
			hold_timing_q <= 1'b0;
		end else if (cmd.commit) begin
			active_q      <= active_d;
			press_phase_q <= press_phase_d;
			start_us_q    <= start_us_d;
			hold_start_q  <= hold_start_d;
			hold_timing_q <= hold_timing_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			code_q    <= code_d;
			drive_q   <= drive_d;
			written_q <= written_d;
		end
	end

	assign status.active   = active_q;
	assign status.div_done = div_done;
	assign event_code      = code_q;
	assign drive_buttons   = drive_q;
	assign drive_written   = written_q;

`ifndef SYNTHESIS
	a_no_hold_while_active: assert property (@(posedge clk) disable iff (!arst_n)
		!(active_q && hold_timing_q))
		else $error("hold timer running while autofire is active");
	a_phase_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		press_phase_q |-> active_q)
		else $error("press phase set without autofire active");
	a_start_in_press: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> press_phase_q)
		else $error("autofire started outside a press phase");
`endif

endmodule

@@ hdl/bafc_ctrl.sv @@
// Controller: sequences accept, period division and commit, and owns the result valid flag.
module bafc_ctrl
	import bafc_pkg::*;
	(
		input  logic         clk,
		input  logic         arst_n,
		input  logic         poll_valid,
		output logic         poll_ready,
		output logic         res_valid,
		input  logic         res_ready,
		input  bafc_status_t status,
		output bafc_cmd_t    cmd
	);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] st_q;
	logic [1:0] st_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign poll_ready = (st_q == ST_IDLE);
	assign accept     = poll_valid && poll_ready;
	assign out_free   = !out_valid_q || res_ready;

	always_comb begin
		st_d          = st_q;
		cmd.load_in   = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_in   = 1'b1;
					cmd.div_start = status.active;
					st_d          = status.active ? ST_DIV : ST_FIN;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					st_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					st_d       = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (st_q == ST_DIV))
		else $error("divider finished outside the divide state");
	a_div_while_active: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> status.active)
		else $error("autofire state changed during the period division");
	a_idle_poll_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !status.active) |=> (st_q == ST_FIN))
		else $error("poll without active autofire did not go straight to commit");
`endif

endmodule

@@ hdl/button_autofire_controller.sv @@
// Top level of the button autofire controller: channels, configuration port and wiring.
//
// One poll (button set, half-controller flag, microsecond timestamp) gives exactly one
// result (event code, buttons to report, written flag). A poll is taken only while no
// other poll is in flight; its result lands in an output register, so the next poll may
// be taken while that result still waits for a transfer. A poll with autofire inactive
// goes straight from accept to commit. A poll with autofire active passes the divide
// state first: the position inside the press+release period is the elapsed time since
// autofire began, modulo the period in microseconds, and a restoring divider resolves it
// one bit per cycle over the TIME_BITS-bit elapsed
// time. Configuration registers (index 0 autofire whitelist, 1 press ms, 2 release ms,
// 3 delay start, 4 right hand, 5 left side mask, 6 right side mask) are written through
// cfg_we/cfg_idx/cfg_wdata and must only change while no poll is in flight; indexes
// beyond the list are ignored. Timestamps wrap modulo 2^TIME_BITS.
module button_autofire_controller
	import bafc_pkg::*;
	#(parameter int TIME_BITS = TIME_BITS_DEF) (
		input  logic                     clk,
		input  logic                     arst_n,
		input  logic                     cfg_we,
		input  cfg_idx_t                 cfg_idx,
		input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
		bafc_poll_if.sink                poll,
		bafc_result_if.source            result
	);

	bafc_cmd_t    cmd;
	bafc_status_t status;

	// controller: handshakes and sequencing of accept, divide and commit
	bafc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll.valid),
		.poll_ready (poll.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath: configuration, autofire state, divider and the result register
	bafc_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.pad_buttons     (poll.pad_buttons),
		.half_controller (poll.half_controller),
		.now_us          (poll.now_us),
		.cmd             (cmd),
		.status          (status),
		.event_code      (result.event_code),
		.drive_buttons   (result.drive_buttons),
		.drive_written   (result.drive_written)
	);

endmodule

@@ sim/tb_button_autofire_controller.sv @@
// Self-checking testbench of the button autofire controller: scripted polls, predictor, checks.
module tb_button_autofire_controller;
	import bafc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TB = TIME_BITS_DEF;

	// Index past the register list; a write there must change nothing.
	localparam cfg_idx_t REG_UNUSED = 3'd7;

	// Button sets for the opening script.
	localparam logic [63:0] DIR_WHITELIST = 64'hFFFF_0000_0000_00FF;
	localparam logic [63:0] DIR_LEFT      = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] DIR_RIGHT     = 64'hFFFF_FFFF_0000_0000;
	localparam logic [63:0] PLAIN_KEYS    = 64'h0000_0000_0000_F000;
	localparam logic [63:0] KEY_LOW       = 64'h0000_0000_0000_0001;
	localparam logic [63:0] KEY_HIGH      = 64'h8000_0000_0000_0000;

	localparam int PHASES          = 12;
	localparam int POLLS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 60;

	typedef enum logic [1:0] {JOB_POLL, JOB_WRITE, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t     kind;
		logic [63:0]   pad;
		logic          half;
		logic [TB-1:0] now;
		cfg_idx_t      idx;
		logic [63:0]   data;
	} job_t;

	typedef struct packed {
		event_t      code;
		logic [63:0] buttons;
		logic        written;
	} turbo_report_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	cfg_idx_t                 cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	bafc_poll_if #(.TIME_BITS(TB)) poll_ch ();
	bafc_result_if                 res_ch ();

	button_autofire_controller #(.TIME_BITS(TB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.poll      (poll_ch),
		.result    (res_ch)
	);

	// Script of polls, register writes and pauses, filled before reset ends.
	job_t          poll_script[$];
	// Reports still owed by the block, oldest first.
	turbo_report_t due_reports[$];

	int polls_queued;
	int polls_sent;
	int reports_seen;
	int mismatches;

	// Shadow registers and state of the predictor.
	logic [63:0]   cfg_whitelist;
	logic [15:0]   cfg_press_ms;
	logic [15:0]   cfg_release_ms;
	logic          cfg_delay_start;
	logic          cfg_right_hand;
	logic [63:0]   cfg_left_mask;
	logic [63:0]   cfg_right_mask;
	logic          af_on;
	logic          in_press;
	logic [TB-1:0] af_origin_us;
	logic [TB-1:0] hold_origin_us;
	logic          hold_armed;

	// Copies the script generator keeps to aim key presses at the whitelist.
	logic [63:0]   gen_whitelist;
	logic [63:0]   gen_left;
	logic [63:0]   gen_right;
	logic          gen_right_hand;
	logic [TB-1:0] gen_now;

	// Sender and receiver pacing.
	int       burst_left;
	int       gap_left;
	int       sink_mode;
	int       sink_mode_left;
	int       sink_tick;
	logic [15:0] sink_pattern;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drive reset with a nonblocking write so the clocked blocks see its falling edge.
	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t ns, report %0d: %s", $time, reports_seen, msg);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Position inside the press+release period, timed from the start of autofire.
	function automatic logic [63:0] period_offset(input logic [TB-1:0] now);
		logic [TB-1:0] since;
		logic [63:0]   span;
		since = now - af_origin_us;
		span = (64'(cfg_press_ms) + 64'(cfg_release_ms)) * US_PER_MS;
		if (span == 64'd0)
			return 64'd0;
		return 64'(since) % span;
	endfunction

	// Advance the predictor by one poll and return the report it must produce.
	function automatic turbo_report_t turbo_outcome(input logic [63:0] pad, input logic half,
			input logic [TB-1:0] now);
		logic [63:0]   wl;
		logic [63:0]   fire;
		logic [TB-1:0] held;
		turbo_report_t rep;
		wl = cfg_whitelist;
		if (half)
			wl &= cfg_right_hand ? cfg_right_mask : cfg_left_mask;
		fire = pad & wl;
		rep.code = EV_IDLE;
		rep.buttons = pad;
		rep.written = 1'b0;
		if (af_on) begin
			rep.written = 1'b1;
			// The finish test looks at the phase left by the previous poll.
			if (in_press && period_offset(now) >= RELEASE_GUARD_US && fire == 64'd0) begin
				rep.code = EV_FINISHING;
				af_on = 1'b0;
				in_press = 1'b0;
				af_origin_us = '0;
				hold_origin_us = '0;
				hold_armed = 1'b0;
			end else begin
				rep.code = EV_EXECUTING;
				in_press = period_offset(now) < 64'(cfg_press_ms) * US_PER_MS;
				rep.buttons = in_press ? pad : pad & ~wl;
			end
		end else if (fire != 64'd0) begin
			if (!hold_armed) begin
				hold_origin_us = now;
				hold_armed = 1'b1;
			end
			held = now - hold_origin_us;
			if (!(cfg_delay_start && held < HOLD_DELAY_US)) begin
				rep.code = EV_STARTING;
				hold_armed = 1'b0;
				hold_origin_us = '0;
				af_on = 1'b1;
				in_press = 1'b1;
				af_origin_us = now;
			end
		end else begin
			hold_armed = 1'b0;
			hold_origin_us = '0;
		end
		return rep;
	endfunction

	task automatic apply_write(input cfg_idx_t idx, input logic [63:0] data);
		case (idx)
			REG_AUTOFIRE_MASK:   cfg_whitelist = data;
			REG_PRESS_MS:        cfg_press_ms = data[15:0];
			REG_RELEASE_MS:      cfg_release_ms = data[15:0];
			REG_DELAY_START:     cfg_delay_start = data[0];
			REG_RIGHT_HAND:      cfg_right_hand = data[0];
			REG_LEFT_SIDE_MASK:  cfg_left_mask = data;
			REG_RIGHT_SIDE_MASK: cfg_right_mask = data;
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- script building

	task automatic add_poll(input logic [63:0] pad, input logic half, input logic [TB-1:0] step);
		job_t j;
		gen_now += step;
		j.kind = JOB_POLL;
		j.pad = pad;
		j.half = half;
		j.now = gen_now;
		j.idx = REG_AUTOFIRE_MASK;
		j.data = '0;
		poll_script.push_back(j);
		polls_queued++;
	endtask

	task automatic add_write(input cfg_idx_t idx, input logic [63:0] data);
		job_t j;
		j.kind = JOB_WRITE;
		j.pad = '0;
		j.half = 1'b0;
		j.now = '0;
		j.idx = idx;
		j.data = data;
		poll_script.push_back(j);
		case (idx)
			REG_AUTOFIRE_MASK:   gen_whitelist = data;
			REG_RIGHT_HAND:      gen_right_hand = data[0];
			REG_LEFT_SIDE_MASK:  gen_left = data;
			REG_RIGHT_SIDE_MASK: gen_right = data;
			default: ;
		endcase
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = JOB_DRAIN;
		j.pad = '0;
		j.half = 1'b0;
		j.now = '0;
		j.idx = REG_AUTOFIRE_MASK;
		j.data = '0;
		poll_script.push_back(j);
	endtask

	// Mostly millisecond spacing; now and then a tiny step, a step of up to 400 ms or a jump anywhere in time.
	function automatic logic [TB-1:0] rnd_step();
		case ($urandom_range(0, 9))
			0:       return TB'($urandom_range(0, 999));
			7, 8:    return TB'($urandom_range(60000, 400000));
			9:       return TB'(rnd64());
			default: return TB'($urandom_range(1000, 60000));
		endcase
	endfunction

	// Hold some whitelisted keys over a random run of polls, which may start autofire, then let go of them.
	task automatic hold_then_let_go();
		logic        half;
		logic [63:0] wl;
		logic [63:0] fire;
		int          holds;
		int          lets;
		half = ($urandom_range(0, 3) == 0);
		wl = gen_whitelist;
		if (half)
			wl &= gen_right_hand ? gen_right : gen_left;
		fire = rnd64() & wl;
		if (fire == 64'd0)
			fire = wl & (~wl + 64'd1);
		holds = $urandom_range(2, 14);
		lets = $urandom_range(1, 8);
		repeat (holds) begin
			// Drop the keys for one poll now and then to break the hold.
			if ($urandom_range(0, 11) == 0)
				add_poll(rnd64() & ~wl, half, TB'($urandom_range(5000, 60000)));
			else if ($urandom_range(0, 2) == 0)
				add_poll((rnd64() & ~wl) | (rnd64() & wl) | fire, half,
					TB'($urandom_range(5000, 60000)));
			else
				add_poll((rnd64() & ~wl) | fire, half, TB'($urandom_range(5000, 60000)));
		end
		repeat (lets)
			add_poll(rnd64() & rnd64() & ~wl, half, TB'($urandom_range(5000, 90000)));
	endtask

	// Write every register; the first phases take the extremes of the period lengths.
	task automatic configure_phase(input int k);
		logic [63:0] wl;
		logic [15:0] pm;
		logic [15:0] rm;
		case (k % 4)
			0:       wl = '1;
			1:       wl = rnd64() & rnd64() & rnd64();
			default: wl = rnd64();
		endcase
		case (k)
			0:       begin pm = 16'd1;     rm = 16'd1;     end
			1:       begin pm = 16'd65535; rm = 16'd65535; end
			2:       begin pm = 16'd1;     rm = 16'd65535; end
			3:       begin pm = 16'd65535; rm = 16'd1;     end
			default: begin
				pm = 16'($urandom_range(20, 400));
				rm = 16'($urandom_range(20, 400));
			end
		endcase
		add_write(REG_AUTOFIRE_MASK, wl);
		// Fill the unused upper bits with noise; only the register width counts.
		add_write(REG_PRESS_MS, {48'(rnd64()), pm});
		add_write(REG_RELEASE_MS, {48'(rnd64()), rm});
		add_write(REG_DELAY_START, {63'(rnd64()), 1'((k % 3) != 1)});
		add_write(REG_RIGHT_HAND, {63'(rnd64()), 1'((k / 2) % 2)});
		case (k % 5)
			0:       add_write(REG_LEFT_SIDE_MASK, '0);
			2:       add_write(REG_LEFT_SIDE_MASK, '1);
			default: add_write(REG_LEFT_SIDE_MASK, rnd64());
		endcase
		case (k % 5)
			1:       add_write(REG_RIGHT_SIDE_MASK, '1);
			3:       add_write(REG_RIGHT_SIDE_MASK, '0);
			default: add_write(REG_RIGHT_SIDE_MASK, rnd64());
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus and end

	initial begin : run_script
		int target;
		int pick;
		polls_queued = 0;
		mismatches = 0;
		gen_whitelist = '0;
		gen_left = '0;
		gen_right = '0;
		gen_right_hand = 1'b1;
		gen_now = '0;

		// Reset whitelist is empty: nothing can autofire yet.
		add_poll('0, 1'b0, 0);
		add_poll('1, 1'b1, 1000);
		add_write(REG_AUTOFIRE_MASK, DIR_WHITELIST);
		add_write(REG_LEFT_SIDE_MASK, DIR_LEFT);
		add_write(REG_RIGHT_SIDE_MASK, DIR_RIGHT);
		add_write(REG_UNUSED, '1);

		// Delayed start: idle until the keys have been down for exactly 200 ms.
		add_poll(KEY_LOW | PLAIN_KEYS, 1'b0, 5000);
		add_poll(KEY_LOW | PLAIN_KEYS, 1'b0, 100000);
		add_poll(KEY_LOW | PLAIN_KEYS, 1'b0, 99999);
		add_poll(KEY_LOW | PLAIN_KEYS, 1'b0, 1);
		// Press phase passes everything, release phase strips the whitelisted keys.
		add_poll('1, 1'b0, 50000);
		add_poll('1, 1'b0, 80000);
		// Keys up during release: no finish, since the last phase was release.
		add_poll(PLAIN_KEYS, 1'b0, 20000);
		// Early in the next press phase, inside the guard: still executing.
		add_poll(PLAIN_KEYS, 1'b0, 60000);
		// Past the guard with the keys up: finish.
		add_poll(PLAIN_KEYS, 1'b0, 35000);

		// Hold off until every report is in before touching the registers again.
		add_drain();
		add_write(REG_DELAY_START, '0);
		// Half controller, right side: immediate start, then a left-side key does not count.
		add_poll(KEY_HIGH, 1'b1, 7000);
		add_poll(KEY_LOW, 1'b1, 40000);
		add_write(REG_RIGHT_HAND, '0);
		add_poll(KEY_HIGH, 1'b1, 3000);
		add_poll(KEY_LOW, 1'b1, 3000);
		add_poll('0, 1'b0, 35000);

		// Hold across the wrap of the timestamp.
		add_write(REG_DELAY_START, 64'd1);
		gen_now = '1 - TB'(99999);
		add_poll(KEY_LOW, 1'b0, 0);
		add_poll(KEY_LOW, 1'b0, 150000);
		add_poll(KEY_LOW, 1'b0, 60000);
		add_poll(KEY_LOW, 1'b0, 20000);
		add_poll(KEY_LOW, 1'b0, 100000);

		// Random phases: mostly hold-and-release sequences, some noise, a few pauses.
		for (int k = 0; k < PHASES; k++) begin
			configure_phase(k);
			if (k == 5)
				gen_now = '1 - TB'(300000);
			target = polls_queued + POLLS_PER_PHASE;
			while (polls_queued < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					hold_then_let_go();
				else if (pick < 97)
					repeat ($urandom_range(1, 6))
						add_poll(rnd64(), 1'($urandom_range(0, 1)), rnd_step());
				else
					add_drain();
			end
		end

		// Wait for every poll to go out and every report to come back, then settle.
		while (polls_sent != polls_queued || due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------- poll driver

	// Feed the script to the block. A register write or a pause waits until no report
	// is owed, so the block is idle. Polls go out in bursts with random gaps.
	always @(posedge clk or negedge arst_n) begin : drive_polls
		job_t j;
		logic next_valid;
		logic next_we;
		if (!arst_n) begin
			poll_ch.valid <= 1'b0;
			poll_ch.pad_buttons <= '0;
			poll_ch.half_controller <= 1'b0;
			poll_ch.now_us <= '0;
			cfg_we <= 1'b0;
			cfg_idx <= REG_AUTOFIRE_MASK;
			cfg_wdata <= '0;
			burst_left = 1;
			gap_left = 0;
			polls_sent = 0;
			cfg_whitelist = '0;
			cfg_press_ms = PRESS_MS_RST;
			cfg_release_ms = RELEASE_MS_RST;
			cfg_delay_start = 1'b1;
			cfg_right_hand = 1'b1;
			cfg_left_mask = '0;
			cfg_right_mask = '0;
			af_on = 1'b0;
			in_press = 1'b0;
			af_origin_us = '0;
			hold_origin_us = '0;
			hold_armed = 1'b0;
		end else begin
			next_valid = poll_ch.valid;
			next_we = 1'b0;
			// Predict on the transfer, from the payload that was on the wires.
			if (poll_ch.valid && poll_ch.ready) begin
				due_reports.push_back(turbo_outcome(poll_ch.pad_buttons,
					poll_ch.half_controller, poll_ch.now_us));
				polls_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid && poll_script.size() > 0) begin
				j = poll_script[0];
				case (j.kind)
					JOB_POLL: begin
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							poll_ch.pad_buttons <= j.pad;
							poll_ch.half_controller <= j.half;
							poll_ch.now_us <= j.now;
							next_valid = 1'b1;
							void'(poll_script.pop_front());
							burst_left--;
							if (burst_left <= 0) begin
								burst_left = $urandom_range(1, 24);
								case ($urandom_range(0, 3))
									0:       gap_left = 0;
									1:       gap_left = $urandom_range(13, 70);
									default: gap_left = $urandom_range(1, 12);
								endcase
							end
						end
					end
					JOB_WRITE: begin
						if (due_reports.size() == 0) begin
							next_we = 1'b1;
							cfg_idx <= j.idx;
							cfg_wdata <= j.data;
							apply_write(j.idx, j.data);
							void'(poll_script.pop_front());
						end
					end
					default: begin
						if (due_reports.size() == 0)
							void'(poll_script.pop_front());
					end
				endcase
			end
			poll_ch.valid <= next_valid;
			cfg_we <= next_we;
		end
	end

	// ---------------------------------------------------------------- report monitor

	// Check each transferred report against the oldest one owed. Ready follows modes picked
	// at random: always ready, ready on two draws in three, or a rotating word.
	always @(posedge clk or negedge arst_n) begin : check_reports
		turbo_report_t want;
		logic next_ready;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			reports_seen = 0;
			sink_mode = 0;
			sink_mode_left = 0;
			sink_tick = 0;
			sink_pattern = 16'hFFFF;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_reports.size() == 0) begin
					flag_mismatch("report arrived with none owed");
				end else begin
					want = due_reports.pop_front();
					if (res_ch.event_code != want.code)
						flag_mismatch($sformatf("event_code %0d, want %0d",
							res_ch.event_code, want.code));
					if (res_ch.drive_buttons != want.buttons)
						flag_mismatch($sformatf("drive_buttons %h, want %h",
							res_ch.drive_buttons, want.buttons));
					if (res_ch.drive_written != want.written)
						flag_mismatch($sformatf("drive_written %0d, want %0d",
							res_ch.drive_written, want.written));
				end
				reports_seen++;
			end
			if (sink_mode_left <= 0) begin
				sink_mode = $urandom_range(0, 2);
				sink_mode_left = $urandom_range(50, 400);
				sink_pattern = 16'($urandom) | 16'h0001;
			end
			sink_mode_left--;
			sink_tick = (sink_tick + 1) % 16;
			case (sink_mode)
				0:       next_ready = 1'b1;
				1:       next_ready = ($urandom_range(0, 2) != 0);
				default: next_ready = sink_pattern[sink_tick];
			endcase
			res_ch.ready <= next_ready;
		end
	end

endmodule

@@ button_autofire_controller.f @@
hdl/bafc_pkg.sv
hdl/bafc_poll_if.sv
hdl/bafc_result_if.sv
hdl/bafc_div.sv
hdl/bafc_dp.sv
hdl/bafc_ctrl.sv
hdl/button_autofire_controller.sv
sim/tb_button_autofire_controller.sv
